/* rtl/ogi_pkg.sv */
// ----------------------------------------------------------------------------
// ogi_pkg: shared types and constants for the occupancy grid inflation block
// Cell codes, request kinds, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ogi_pkg;

  typedef logic [1:0] cell_code_t;
  typedef logic [2:0] req_type_t;
  typedef logic signed [4:0] off_t;   // inflate offset, -15..15

  localparam cell_code_t CODE_FREE     = 2'd0;
  localparam cell_code_t CODE_UNKNOWN  = 2'd1;
  localparam cell_code_t CODE_OCCUPIED = 2'd2;
  localparam cell_code_t CODE_INFLATED = 2'd3;

  localparam req_type_t REQ_READ    = 3'd0;
  localparam req_type_t REQ_WRITE   = 3'd1;
  localparam req_type_t REQ_WR_OCC  = 3'd2;
  localparam req_type_t REQ_INFLATE = 3'd3;
  localparam req_type_t REQ_CLEAR   = 3'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_MAX     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED_MIN = 2'd3;

  localparam logic [6:0] GRID_WIDTH_RST   = 7'd64;
  localparam logic [6:0] GRID_HEIGHT_RST  = 7'd64;
  localparam logic [7:0] FREE_MAX_RST     = 8'd99;
  localparam logic [7:0] OCCUPIED_MIN_RST = 8'd156;

endpackage

/* rtl/occupancy_grid_inflation.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_inflation: 2-bit planner grid with disk-shaped inflation
// Read / write / write-occupancy: one item per cycle sustained while the result
//   channel does not stall; the result register loads from DONE (single read port).
// Clear: a sweep over every cell (one cell per cycle on the write port), then DONE.
// Inflate: SRC, CHK, ADV per cell in use; (2r+1)**2 NB per occupied/unknown cell.
// Reset: synchronous; a sweep over all cells sets them unknown, with in_stall high.
// ----------------------------------------------------------------------------
module occupancy_grid_inflation #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ogi_pkg::req_type_t             in_req_type,
  input  logic signed [7:0]              in_col,
  input  logic signed [7:0]              in_row,
  input  ogi_pkg::cell_code_t            in_cell_code,
  input  logic [7:0]                     in_occupancy,
  input  logic [3:0]                     in_radius,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output ogi_pkg::cell_code_t            out_read_code,
  output logic                           out_inside_res,
  output ogi_pkg::req_type_t             out_echo_type,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ogi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ogi_pkg::*;

  // Store addressing: {row, col}, each coordinate on its own bit field.
  localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  // Sequencer states
  localparam logic [2:0] S_INIT_CLR = 3'd0;  // clearing sweep after reset
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DONE     = 3'd2;  // result ready for output register
  localparam logic [2:0] S_CLR      = 3'd3;  // clearing sweep for a clear item
  localparam logic [2:0] S_INF_SRC  = 3'd4;  // read candidate source cell
  localparam logic [2:0] S_INF_CHK  = 3'd5;  // source test
  localparam logic [2:0] S_INF_NB   = 3'd6;  // walk disk offsets
  localparam logic [2:0] S_INF_ADV  = 3'd7;  // step to next cell

  // ---------------------------------------------------------------- registers
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  cell_code_t       out_read_code_r, out_read_code_nxt;
  logic             out_inside_res_r, out_inside_res_nxt;
  req_type_t        out_echo_type_r, out_echo_type_nxt;

  logic [6:0]       grid_width_r, grid_height_r;
  logic [7:0]       free_max_r, occupied_min_r;

  req_type_t        req_type_r, req_type_nxt;
  logic             inside_r, inside_nxt;
  logic [3:0]       rad_r, rad_nxt;
  logic [6:0]       sr_r, sr_nxt;     // scan row
  logic [6:0]       sc_r, sc_nxt;     // scan column
  off_t             dr_r, dr_nxt;
  off_t             dc_r, dc_nxt;

  // Cell store, one write and one registered read per cycle.
  cell_code_t       cell_mem [DEPTH];
  cell_code_t       rdata_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  cell_code_t       mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cell_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------- effective sizes
  logic [6:0] eff_w, eff_h;
  assign eff_w = ({2'b00, grid_width_r}  > 9'(MAX_WIDTH))  ? 7'(MAX_WIDTH)  : grid_width_r;
  assign eff_h = ({2'b00, grid_height_r} > 9'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height_r;

  // ------------------------------------------------------ request decoding
  logic          go, out_free;
  logic          in_inside, in_has_coord;
  logic [AW-1:0] in_addr;
  cell_code_t    occ_code;
  logic [3:0]    rad_eff;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_DONE) && out_free));
  assign go       = in_valid && !in_stall;

  assign in_inside = !in_col[7] && (in_col[6:0] < eff_w) &&
                     !in_row[7] && (in_row[6:0] < eff_h);
  assign in_has_coord = (in_req_type == REQ_READ) || (in_req_type == REQ_WRITE) ||
                        (in_req_type == REQ_WR_OCC);
  assign in_addr = {RW'(in_row[6:0]), CW'(in_col[6:0])};

  always_comb begin
    priority if (in_occupancy <= free_max_r) begin
      occ_code = CODE_FREE;
    end else if (in_occupancy >= occupied_min_r) begin
      occ_code = CODE_OCCUPIED;
    end else begin
      occ_code = CODE_UNKNOWN;
    end
  end

  assign rad_eff = ({2'b00, in_radius} > 6'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : in_radius;

  // ----------------------------------------------------- inflate datapath
  // Neighbor of the current source at offset (dr, dc); only free cells of
  // the disk are rewritten, so sources never change during the pass.
  logic signed [8:0] nr, nc;
  logic signed [9:0] drx, dcx;
  logic [9:0]        dist_sq, rad_sq;
  logic              nb_ok, src_hit, dc_last, dr_last;
  logic [AW-1:0]     scan_addr, nb_addr;
  off_t              rad_s;

  assign rad_s   = $signed({1'b0, rad_r});
  assign nr      = $signed({2'b00, sr_r}) + 9'(dr_r);
  assign nc      = $signed({2'b00, sc_r}) + 9'(dc_r);
  assign drx     = 10'(dr_r);
  assign dcx     = 10'(dc_r);
  assign dist_sq = $unsigned(10'(drx * drx)) + $unsigned(10'(dcx * dcx));
  assign rad_sq  = {6'b0, rad_r} * {6'b0, rad_r};
  assign nb_ok   = !nr[8] && (nr[7:0] < {1'b0, eff_h}) &&
                   !nc[8] && (nc[7:0] < {1'b0, eff_w}) && (dist_sq <= rad_sq);
  assign scan_addr = {RW'(sr_r), CW'(sc_r)};
  assign nb_addr   = {RW'(nr[6:0]), CW'(nc[6:0])};
  assign src_hit   = (rdata_r == CODE_OCCUPIED) || (rdata_r == CODE_UNKNOWN);
  assign dc_last   = (dc_r == rad_s);
  assign dr_last   = (dr_r == rad_s);

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    pend_v_nxt         = 1'b0;
    pend_addr_nxt      = pend_addr_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_read_code_nxt  = out_read_code_r;
    out_inside_res_nxt = out_inside_res_r;
    out_echo_type_nxt  = out_echo_type_r;
    req_type_nxt       = req_type_r;
    inside_nxt         = inside_r;
    rad_nxt            = rad_r;
    sr_nxt             = sr_r;
    sc_nxt             = sc_r;
    dr_nxt             = dr_r;
    dc_nxt             = dc_r;
    mem_re             = 1'b0;
    mem_raddr          = scan_addr;
    // write-back of the neighbor read in the previous cycle, if still free
    mem_we             = pend_v_r && (rdata_r == CODE_FREE);
    mem_waddr          = pend_addr_r;
    mem_wdata          = CODE_INFLATED;

    unique case (state_r)
      S_INIT_CLR, S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = CODE_UNKNOWN;
        cnt_nxt   = cnt_r + AW'(1);
        if (&cnt_r) begin
          state_nxt = (state_r == S_CLR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_echo_type_nxt  = req_type_r;
          out_inside_res_nxt = inside_r;
          if (req_type_r == REQ_READ) begin
            out_read_code_nxt = inside_r ? rdata_r : CODE_OCCUPIED;
          end else begin
            out_read_code_nxt = CODE_FREE;
          end
          state_nxt = S_IDLE;
        end
      end
      S_INF_SRC: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
        state_nxt = S_INF_CHK;
      end
      S_INF_CHK: begin
        if (src_hit) begin
          dr_nxt    = 5'sd0 - rad_s;
          dc_nxt    = 5'sd0 - rad_s;
          state_nxt = S_INF_NB;
        end else begin
          state_nxt = S_INF_ADV;
        end
      end
      S_INF_NB: begin
        if (nb_ok) begin
          mem_re        = 1'b1;
          mem_raddr     = nb_addr;
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = nb_addr;
        end
        if (dc_last) begin
          dc_nxt = 5'sd0 - rad_s;
          if (dr_last) begin
            state_nxt = S_INF_ADV;
          end else begin
            dr_nxt = dr_r + 5'sd1;
          end
        end else begin
          dc_nxt = dc_r + 5'sd1;
        end
      end
      S_INF_ADV: begin
        if ({1'b0, sc_r} + 8'd1 < {1'b0, eff_w}) begin
          sc_nxt    = sc_r + 7'd1;
          state_nxt = S_INF_SRC;
        end else begin
          sc_nxt = 7'd0;
          if ({1'b0, sr_r} + 8'd1 < {1'b0, eff_h}) begin
            sr_nxt    = sr_r + 7'd1;
            state_nxt = S_INF_SRC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // New item: taken in IDLE, or in DONE while the result moves out.
    if (go) begin
      req_type_nxt = in_req_type;
      inside_nxt   = in_has_coord ? in_inside : 1'b1;
      state_nxt    = S_DONE;
      unique case (in_req_type)
        REQ_READ: begin
          mem_re    = in_inside;
          mem_raddr = in_addr;
        end
        REQ_WRITE, REQ_WR_OCC: begin
          mem_we    = in_inside;
          mem_waddr = in_addr;
          mem_wdata = (in_req_type == REQ_WRITE) ? in_cell_code : occ_code;
        end
        REQ_INFLATE: begin
          rad_nxt = rad_eff;
          sr_nxt  = 7'd0;
          sc_nxt  = 7'd0;
          if ((rad_eff != 4'd0) && (eff_w != 7'd0) && (eff_h != 7'd0)) begin
            state_nxt = S_INF_SRC;
          end
        end
        REQ_CLEAR: begin
          cnt_nxt   = '0;
          state_nxt = S_CLR;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_INIT_CLR;
      cnt_r          <= '0;
      pend_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      grid_width_r   <= GRID_WIDTH_RST;
      grid_height_r  <= GRID_HEIGHT_RST;
      free_max_r     <= FREE_MAX_RST;
      occupied_min_r <= OCCUPIED_MIN_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:   grid_width_r   <= cfg_data[6:0];
          CFG_GRID_HEIGHT:  grid_height_r  <= cfg_data[6:0];
          CFG_FREE_MAX:     free_max_r     <= cfg_data;
          CFG_OCCUPIED_MIN: occupied_min_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_addr_r      <= pend_addr_nxt;
    out_read_code_r  <= out_read_code_nxt;
    out_inside_res_r <= out_inside_res_nxt;
    out_echo_type_r  <= out_echo_type_nxt;
    req_type_r       <= req_type_nxt;
    inside_r         <= inside_nxt;
    rad_r            <= rad_nxt;
    sr_r             <= sr_nxt;
    sc_r             <= sc_nxt;
    dr_r             <= dr_nxt;
    dc_r             <= dc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_code  = out_read_code_r;
  assign out_inside_res = out_inside_res_r;
  assign out_echo_type  = out_echo_type_r;

`ifndef SYNTHESIS
  // clearing sweep holds off requests right after reset
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during reset sweep");

  // inflate write-back and request writes never share the write port
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n) !(pend_v_r && go))
    else $error("write port conflict");

  a_oob_read: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && (out_echo_type == REQ_READ) && !out_inside_res)
      |-> (out_read_code == CODE_OCCUPIED))
    else $error("out-of-bounds read not occupied");

  a_non_read: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && (out_echo_type != REQ_READ)) |-> (out_read_code == CODE_FREE))
    else $error("non-read item returned a code");
`endif

endmodule

/* verif/ogi_grid_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ogi_grid_scoreboard_pkg: request/result types and grid scoreboard
// Mirrors the cell store and the four registers, computes the result of each
// accepted request, and checks results in order.
// ----------------------------------------------------------------------------
package ogi_grid_scoreboard_pkg;

  import ogi_pkg::*;

  localparam int GRID_MAX_W      = 64;
  localparam int GRID_MAX_H      = 64;
  localparam int GRID_MAX_RADIUS = 15;

  // kinds with no function: no effect, in grid 1
  localparam req_type_t REQ_RSVD_A = 3'd5;
  localparam req_type_t REQ_RSVD_B = 3'd6;
  localparam req_type_t REQ_RSVD_C = 3'd7;

  typedef struct {
    req_type_t         kind;
    logic signed [7:0] col;
    logic signed [7:0] row;
    cell_code_t        code;
    logic [7:0]        occ;
    logic [3:0]        rad;
  } grid_req_t;

  typedef struct {
    cell_code_t code;
    logic       in_grid;
    req_type_t  kind;
  } grid_resp_t;

  class grid_scoreboard;
    cell_code_t store [GRID_MAX_W*GRID_MAX_H];
    logic [6:0] cols;
    logic [6:0] rows;
    logic [7:0] free_max;
    logic [7:0] occ_min;
    grid_resp_t expected_resp [$];
    int         errors;

    function new();
      clear_store();
      cols     = GRID_WIDTH_RST;
      rows     = GRID_HEIGHT_RST;
      free_max = FREE_MAX_RST;
      occ_min  = OCCUPIED_MIN_RST;
      errors   = 0;
    endfunction

    function void clear_store();
      foreach (store[i]) store[i] = CODE_UNKNOWN;
    endfunction

    function int used_cols();
      return (cols > GRID_MAX_W) ? GRID_MAX_W : int'(cols);
    endfunction

    function int used_rows();
      return (rows > GRID_MAX_H) ? GRID_MAX_H : int'(rows);
    endfunction

    function bit on_grid(int c, int r);
      return c >= 0 && c < used_cols() && r >= 0 && r < used_rows();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH:   cols = val[6:0];
        CFG_GRID_HEIGHT:  rows = val[6:0];
        CFG_FREE_MAX:     free_max = val;
        CFG_OCCUPIED_MIN: occ_min = val;
        default: ;
      endcase
    endfunction

    function bit is_source(cell_code_t v);
      return v == CODE_OCCUPIED || v == CODE_UNKNOWN;
    endfunction

    // rough cost of an inflate pass in clock cycles
    function int inflate_cycles(int rad);
      int n;
      n = 0;
      for (int r = 0; r < used_rows(); r++)
        for (int c = 0; c < used_cols(); c++)
          if (is_source(store[r*GRID_MAX_W + c])) n++;
      return 3*used_cols()*used_rows() + (2*rad + 1)*(2*rad + 1)*n;
    endfunction

    // sources never change and new inflated cells are not sources, so in place is exact
    function void inflate(int rad);
      int nr;
      int nc;
      for (int r = 0; r < used_rows(); r++)
        for (int c = 0; c < used_cols(); c++) begin
          if (!is_source(store[r*GRID_MAX_W + c])) continue;
          for (int dr = -rad; dr <= rad; dr++)
            for (int dc = -rad; dc <= rad; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if (!on_grid(nc, nr) || dr*dr + dc*dc > rad*rad) continue;
              if (store[nr*GRID_MAX_W + nc] == CODE_FREE)
                store[nr*GRID_MAX_W + nc] = CODE_INFLATED;
            end
        end
    endfunction

    function void note_request(grid_req_t q);
      grid_resp_t e;
      int         c;
      int         r;
      int         rad;
      cell_code_t v;
      c = int'(q.col);
      r = int'(q.row);
      e.code    = '0;
      e.in_grid = 1'b1;
      e.kind    = q.kind;
      case (q.kind)
        REQ_READ, REQ_WRITE, REQ_WR_OCC: begin
          e.in_grid = on_grid(c, r);
          if (q.kind == REQ_READ) begin
            if (e.in_grid) e.code = store[r*GRID_MAX_W + c];
            else e.code = CODE_OCCUPIED;
          end else if (e.in_grid) begin
            v = q.code;
            if (q.kind == REQ_WR_OCC) begin
              if (q.occ <= free_max) v = CODE_FREE;
              else if (q.occ >= occ_min) v = CODE_OCCUPIED;
              else v = CODE_UNKNOWN;
            end
            store[r*GRID_MAX_W + c] = v;
          end
        end
        REQ_INFLATE: begin
          rad = int'(q.rad);
          if (rad > GRID_MAX_RADIUS) rad = GRID_MAX_RADIUS;
          if (rad > 0) inflate(rad);
        end
        REQ_CLEAR: clear_store();
        default: ;
      endcase
      expected_resp.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 30) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_resp(grid_resp_t got);
      grid_resp_t e;
      if (expected_resp.size() == 0) begin
        report($sformatf("result kind %0d with no request pending", got.kind));
        return;
      end
      e = expected_resp.pop_front();
      if (got.kind !== e.kind)
        report($sformatf("echo_type %0d, want %0d", got.kind, e.kind));
      if (got.in_grid !== e.in_grid)
        report($sformatf("kind %0d inside_res %0b, want %0b", e.kind, got.in_grid,
                         e.in_grid));
      if (got.code !== e.code)
        report($sformatf("kind %0d read_code %0d, want %0d", e.kind, got.code, e.code));
    endtask

    function int pending();
      return expected_resp.size();
    endfunction
  endclass

endpackage

/* verif/tb_occupancy_grid_inflation.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_inflation: self-checking bench for the occupancy grid
// Directed corner items, then randomized phases over several grid sizes and
// thresholds, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_inflation;

  import ogi_pkg::*;
  import ogi_grid_scoreboard_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  req_type_t             in_req_type;
  logic signed [7:0]     in_col;
  logic signed [7:0]     in_row;
  cell_code_t            in_cell_code;
  logic [7:0]            in_occupancy;
  logic [3:0]            in_radius;
  logic                  out_valid;
  logic                  out_stall;
  cell_code_t            out_read_code;
  logic                  out_inside_res;
  req_type_t             out_echo_type;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_scoreboard sb = new();

  bit calm;        // no idling on either side while set
  int n_results;   // accepted results so far
  int cur_w;       // register values of the current phase, for stimulus shaping
  int cur_h;
  int cur_fm;
  int cur_om;

  occupancy_grid_inflation #(
    .MAX_WIDTH  (GRID_MAX_W),
    .MAX_HEIGHT (GRID_MAX_H),
    .MAX_RADIUS (GRID_MAX_RADIUS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_cell_code   (in_cell_code),
    .in_occupancy   (in_occupancy),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_code  (out_read_code),
    .out_inside_res (out_inside_res),
    .out_echo_type  (out_echo_type),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. Worst case is dominated by inflate passes (capped per item) and
  // clear sweeps; this is several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, none while calm, and once a long hold-off so
  // the block backs up and stalls its input while items keep coming.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && n_results >= 500) begin
        held      = 1'b1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
    end
  end

  // Result monitor: every accepted result goes to the scoreboard in order.
  always @(posedge clk) begin
    grid_resp_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.code    = out_read_code;
      got.in_grid = out_inside_res;
      got.kind    = out_echo_type;
      sb.check_resp(got);
      n_results++;
    end
  end

  function automatic grid_req_t mk(req_type_t kind, int c, int r, cell_code_t code,
                                   int occ, int rad);
    grid_req_t q;
    q.kind = kind;
    q.col  = c[7:0];
    q.row  = r[7:0];
    q.code = code;
    q.occ  = occ[7:0];
    q.rad  = rad[3:0];
    return q;
  endfunction

  // Mostly in the grid, some just past an edge, a few anywhere in 8 bits.
  function automatic logic [7:0] rand_coord(int lim);
    int p;
    int v;
    p = $urandom_range(0, 99);
    if (p < 80) v = $urandom_range(0, lim - 1);
    else if (p < 92) v = int'($urandom_range(0, lim + 3)) - 2;
    else v = $urandom_range(0, 255);
    return v[7:0];
  endfunction

  function automatic grid_req_t random_req();
    grid_req_t q;
    int p;
    int base;
    int rad;
    q.col  = rand_coord(cur_w);
    q.row  = rand_coord(cur_h);
    // free cells are what inflation acts on, so favor them
    q.code = ($urandom_range(0, 99) < 45) ? CODE_FREE : cell_code_t'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      q.occ = 8'($urandom_range(0, 255));
    end else begin
      // hug the thresholds
      base = $urandom_range(0, 1) ? cur_fm : cur_om;
      base = base + int'($urandom_range(0, 2)) - 1;
      q.occ = (base < 0) ? 8'd0 : (base > 255) ? 8'd255 : base[7:0];
    end
    q.rad = 4'($urandom_range(0, 15));
    p = $urandom_range(0, 99);
    if (p < 39) q.kind = REQ_READ;
    else if (p < 63) q.kind = REQ_WRITE;
    else if (p < 89) q.kind = REQ_WR_OCC;
    else if (p < 94) q.kind = REQ_INFLATE;
    else if (p < 96) q.kind = REQ_CLEAR;
    else q.kind = req_type_t'(REQ_RSVD_A + $urandom_range(0, 2));
    if (q.kind == REQ_INFLATE) begin
      // keep each pass short: shrink the radius until the pass is cheap
      rad = int'(q.rad);
      while (rad > 0 && sb.inflate_cycles(rad) > 8000) rad--;
      q.rad = rad[3:0];
    end
    return q;
  endfunction

  // Offer one item, hold it until accepted, then maybe idle a while.
  task automatic send_req(grid_req_t q);
    in_valid     <= 1'b1;
    in_req_type  <= q.kind;
    in_col       <= q.col;
    in_row       <= q.row;
    in_cell_code <= q.code;
    in_occupancy <= q.occ;
    in_radius    <= q.rad;
    do @(posedge clk); while (in_stall);
    sb.note_request(q);
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(0, 99) < 26) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Every item yields a result, so an empty queue plus a short pause is idle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[7:0];
    @(posedge clk);
    sb.write_reg(idx, val[7:0]);
  endtask

  task automatic set_grid(int w, int h, int fm, int om);
    put_reg(CFG_GRID_WIDTH, w);
    put_reg(CFG_GRID_HEIGHT, h);
    put_reg(CFG_FREE_MAX, fm);
    put_reg(CFG_OCCUPIED_MIN, om);
    cfg_we <= 1'b0;
    cur_w  = w;
    cur_h  = h;
    cur_fm = fm;
    cur_om = om;
  endtask

  // Small grids first get every cell written free, so inflation has room to
  // grow; the rest of the phase scatters obstacles, reads and passes.
  task automatic run_phase(int n_items);
    int k;
    k = 0;
    if (cur_w * cur_h <= 64) begin
      for (int r = 0; r < cur_h; r++)
        for (int c = 0; c < cur_w; c++) begin
          send_req(mk(REQ_WRITE, c, r, CODE_FREE, $urandom_range(0, 255),
                      $urandom_range(0, 15)));
          k++;
        end
    end
    for (; k < n_items; k++) send_req(random_req());
  endtask

  initial begin
    calm         = 1'b0;
    n_results    = 0;
    cur_w        = int'(GRID_WIDTH_RST);
    cur_h        = int'(GRID_HEIGHT_RST);
    cur_fm       = int'(FREE_MAX_RST);
    cur_om       = int'(OCCUPIED_MIN_RST);
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req_type  <= REQ_READ;
    in_col       <= '0;
    in_row       <= '0;
    in_cell_code <= CODE_FREE;
    in_occupancy <= '0;
    in_radius    <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_GRID_WIDTH;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset registers (64 x 64). The block clears itself after
    // reset and holds in_stall meanwhile; the first item simply waits.
    send_req(mk(REQ_READ, 0, 0, CODE_FREE, 0, 0));           // unknown after reset
    send_req(mk(REQ_READ, 64, 0, CODE_FREE, 0, 0));          // one past right edge
    send_req(mk(REQ_READ, 127, -128, CODE_INFLATED, 255, 15));
    send_req(mk(REQ_WRITE, 0, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_WRITE, 63, 63, CODE_OCCUPIED, 0, 0));
    send_req(mk(REQ_WRITE, 63, 0, CODE_INFLATED, 0, 0));
    send_req(mk(REQ_WRITE, 0, 63, CODE_UNKNOWN, 0, 0));
    send_req(mk(REQ_WRITE, -128, 127, CODE_INFLATED, 0, 0)); // ignored, flagged
    send_req(mk(REQ_WR_OCC, 1, 0, CODE_INFLATED, 99, 0));    // top of free band
    send_req(mk(REQ_WR_OCC, 2, 0, CODE_FREE, 100, 0));       // just above free
    send_req(mk(REQ_WR_OCC, 3, 0, CODE_FREE, 155, 0));       // just below occupied
    send_req(mk(REQ_WR_OCC, 4, 0, CODE_FREE, 156, 0));
    send_req(mk(REQ_WR_OCC, -1, 0, CODE_FREE, 0, 0));        // out of bounds
    send_req(mk(REQ_READ, 63, 63, CODE_FREE, 0, 0));
    send_req(mk(REQ_READ, 3, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_READ, 4, -1, CODE_FREE, 0, 0));
    send_req(mk(REQ_INFLATE, 0, 0, CODE_FREE, 0, 0));        // radius 0: no change
    send_req(mk(REQ_RSVD_A, 5, 5, CODE_OCCUPIED, 0, 3));
    send_req(mk(REQ_RSVD_B, -5, 5, CODE_OCCUPIED, 0, 3));
    send_req(mk(REQ_RSVD_C, 0, 0, CODE_OCCUPIED, 0, 3));
    send_req(mk(REQ_CLEAR, 0, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_READ, 0, 0, CODE_FREE, 0, 0));           // back to unknown
    stop_sending();
    drain();

    // Directed, 2 x 2 grid: one obstacle, full radius floods the free cells.
    set_grid(2, 2, 99, 156);
    send_req(mk(REQ_WRITE, 0, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_WR_OCC, 1, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_WRITE, 0, 1, CODE_FREE, 0, 0));
    send_req(mk(REQ_WRITE, 1, 1, CODE_OCCUPIED, 0, 0));
    send_req(mk(REQ_INFLATE, 0, 0, CODE_FREE, 0, 15));
    send_req(mk(REQ_READ, 0, 0, CODE_FREE, 0, 0));
    send_req(mk(REQ_READ, 2, 0, CODE_FREE, 0, 0));
    stop_sending();
    drain();

    // Random phases: register extremes first, then random small grids.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_grid(8, 8, 99, 156);
        1: set_grid(64, 64, 0, 255);
        2: set_grid(1, 1, 255, 0);
        3: set_grid(64, 1, 40, 200);
        4: set_grid(1, 64, 200, 30);     // free band above occupied band
        5: set_grid(12, 5, $urandom_range(0, 255), $urandom_range(0, 255));
        default: set_grid($urandom_range(1, 10), $urandom_range(1, 10),
                          $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      calm = (p == 3);
      run_phase((p == 1) ? 120 : 180);
      stop_sending();
      drain();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report("requests left without a result");
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/ogi_pkg.sv
rtl/occupancy_grid_inflation.sv
verif/ogi_grid_scoreboard_pkg.sv
verif/tb_occupancy_grid_inflation.sv
